// File: hdl/aob_pkg.sv
// Package for the alpha-over blend block: widths, latency figures, token types
// and the divide-by-255 helper used by the front end.
// Depends on nothing.
package aob_pkg;

	localparam int unsigned PIX_W        = 8;
	localparam int unsigned NUM_CH       = 3;
	localparam int unsigned NUM_CELLS    = PIX_W;
	localparam int unsigned FRONT_STAGES = 3;
	localparam int unsigned LATENCY      = FRONT_STAGES + NUM_CELLS;

	localparam logic [PIX_W-1:0] CH_MAX  = 8'hFF;
	localparam logic [PIX_W-1:0] CH_ZERO = 8'h00;

	// Reciprocal of 255 scaled by 2^24, exact for dividends below 2^24 - 1.
	localparam logic [16:0] RECIP_255 = 17'd65793;

	typedef logic [PIX_W-1:0] chan_t;

	typedef struct packed {
		chan_t                  alpha;
		chan_t [NUM_CH-1:0]     col;
	} pix_t;

	typedef struct packed {
		logic                   valid;
		chan_t                  alpha;
		chan_t                  dvsr;
		chan_t [NUM_CH-1:0]     rem;
		chan_t [NUM_CH-1:0]     low;
	} div_tok_t;

	function automatic logic [15:0] div255(input logic [23:0] x);
		logic [41:0] prod;
		prod = ({1'b0, x} + 25'd1) * RECIP_255;
		return prod[39:24];
	endfunction

endpackage

// File: hdl/alpha_over_blend.sv
// Alpha-over blend top level: front end followed by a row of divider cells.
// Depends on aob_pkg, aob_front and aob_div_cell.
//
// The block takes one pixel pair per clock whenever busy is low and returns the
// composited pixel from the last divider cell, marked by a one-cycle done strobe;
// results are not held, so the receiver must capture them on that cycle. The
// pipeline is three multiply stages that form the result alpha and the channel
// dividends, followed by eight divider cells that each retire one quotient bit for
// all three color channels. Busy is high only while reset is applied and for the
// first cycle after it; after that each cycle with start high is accepted.
module alpha_over_blend (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] bottom_alpha,
	input  logic [7:0] bottom_red,
	input  logic [7:0] bottom_green,
	input  logic [7:0] bottom_blue,
	input  logic [7:0] top_alpha,
	input  logic [7:0] top_red,
	input  logic [7:0] top_green,
	input  logic [7:0] top_blue,
	output logic       done,
	output logic [7:0] out_alpha,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue
);

	logic              busy_q;
	logic              accept;
	aob_pkg::div_tok_t chain [aob_pkg::NUM_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	aob_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.bottom_alpha (bottom_alpha),
		.bottom_red   (bottom_red),
		.bottom_green (bottom_green),
		.bottom_blue  (bottom_blue),
		.top_alpha    (top_alpha),
		.top_red      (top_red),
		.top_green    (top_green),
		.top_blue     (top_blue),
		.tok          (chain[0])
	);

	for (genvar i = 0; i < aob_pkg::NUM_CELLS; i++) begin : g_cell
		aob_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	assign done      = chain[aob_pkg::NUM_CELLS].valid;
	assign out_alpha = chain[aob_pkg::NUM_CELLS].alpha;
	assign out_red   = chain[aob_pkg::NUM_CELLS].low[0];
	assign out_green = chain[aob_pkg::NUM_CELLS].low[1];
	assign out_blue  = chain[aob_pkg::NUM_CELLS].low[2];

	// Every accepted transaction produces exactly one strobe, a fixed time later.
	a_accept_to_done : assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(aob_pkg::LATENCY) done)
		else $error("accepted transaction did not produce a result");

	a_done_from_accept : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, aob_pkg::LATENCY))
		else $error("result strobe without an accepted transaction");

	// An opaque top pixel passes through the divider chain unchanged.
	a_opaque_pass : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (top_alpha == aob_pkg::CH_MAX)) |-> ##(aob_pkg::LATENCY)
		((out_alpha == aob_pkg::CH_MAX) && (out_red == $past(top_red, aob_pkg::LATENCY))
		&& (out_blue == $past(top_blue, aob_pkg::LATENCY))))
		else $error("opaque top pixel was altered");

	// A transparent top pixel returns the bottom pixel unchanged.
	a_clear_pass : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (top_alpha == aob_pkg::CH_ZERO)) |-> ##(aob_pkg::LATENCY)
		((out_alpha == $past(bottom_alpha, aob_pkg::LATENCY))
		&& (out_green == $past(bottom_green, aob_pkg::LATENCY))))
		else $error("transparent top pixel did not pass the bottom pixel");

endmodule

// File: hdl/aob_div_cell.sv
// One restoring divider cell of the alpha-over blend block: retires one quotient
// bit for each color channel and hands its token to the next cell.
// Depends on aob_pkg.
module aob_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  aob_pkg::div_tok_t tok_in,
	output aob_pkg::div_tok_t tok_out
);

	aob_pkg::div_tok_t nxt;
	aob_pkg::div_tok_t tok_q;
	logic [8:0]        trial [aob_pkg::NUM_CH];
	logic [8:0]        diff  [aob_pkg::NUM_CH];
	logic              ge    [aob_pkg::NUM_CH];

	always_comb begin
		nxt       = tok_in;
		for (int ch = 0; ch < aob_pkg::NUM_CH; ch++) begin
			trial[ch] = {tok_in.rem[ch], tok_in.low[ch][aob_pkg::PIX_W-1]};
			diff[ch]  = trial[ch] - {1'b0, tok_in.dvsr};
			ge[ch]    = trial[ch] >= {1'b0, tok_in.dvsr};
			nxt.rem[ch] = ge[ch] ? diff[ch][aob_pkg::PIX_W-1:0]
				: trial[ch][aob_pkg::PIX_W-1:0];
			nxt.low[ch] = {tok_in.low[ch][aob_pkg::PIX_W-2:0], ge[ch]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: hdl/aob_front.sv
// Front end of the alpha-over blend block: three multiply stages that form the
// result alpha and the channel dividends, then load the first divider cell.
// Depends on aob_pkg.
module aob_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [7:0]        bottom_alpha,
	input  logic [7:0]        bottom_red,
	input  logic [7:0]        bottom_green,
	input  logic [7:0]        bottom_blue,
	input  logic [7:0]        top_alpha,
	input  logic [7:0]        top_red,
	input  logic [7:0]        top_green,
	input  logic [7:0]        top_blue,
	output aob_pkg::div_tok_t tok
);

	aob_pkg::chan_t [aob_pkg::NUM_CH-1:0] bc;
	aob_pkg::chan_t [aob_pkg::NUM_CH-1:0] tc;
	aob_pkg::chan_t                       inv;
	logic                                 byp;
	aob_pkg::pix_t                        pix;

	logic                                 valid_s1;
	logic                                 byp_s1;
	aob_pkg::pix_t                        pix_s1;
	aob_pkg::chan_t                       ta_s1;
	aob_pkg::chan_t [aob_pkg::NUM_CH-1:0] bc_s1;
	logic [15:0]                          ba_inv_s1;
	logic [15:0]                          tcta_s1 [aob_pkg::NUM_CH];

	logic [15:0]                          q_ba;
	logic [8:0]                           ra_sum;
	aob_pkg::chan_t                       ra;
	logic [23:0]                          bprod [aob_pkg::NUM_CH];

	logic                                 valid_s2;
	logic                                 byp_s2;
	aob_pkg::pix_t                        pix_s2;
	aob_pkg::chan_t                       ra_s2;
	logic [15:0]                          tcta_s2 [aob_pkg::NUM_CH];
	logic [23:0]                          bprod_s2 [aob_pkg::NUM_CH];

	logic [16:0]                          num [aob_pkg::NUM_CH];

	logic                                 valid_s3;
	logic                                 byp_s3;
	aob_pkg::pix_t                        pix_s3;
	aob_pkg::chan_t                       ra_s3;
	logic [16:0]                          num_s3 [aob_pkg::NUM_CH];

	logic                                 sat [aob_pkg::NUM_CH];

	assign bc  = {bottom_blue, bottom_green, bottom_red};
	assign tc  = {top_blue, top_green, top_red};
	assign inv = aob_pkg::CH_MAX - top_alpha;
	assign byp = (top_alpha == aob_pkg::CH_MAX) || (top_alpha == aob_pkg::CH_ZERO);

	always_comb begin
		if (top_alpha == aob_pkg::CH_MAX) begin
			pix.alpha = top_alpha;
			pix.col   = tc;
		end else begin
			pix.alpha = bottom_alpha;
			pix.col   = bc;
		end
	end

	always_comb begin
		q_ba   = aob_pkg::div255({8'h00, ba_inv_s1});
		ra_sum = {1'b0, ta_s1} + {1'b0, q_ba[7:0]};
		ra     = (ra_sum > {1'b0, aob_pkg::CH_MAX}) ? aob_pkg::CH_MAX : ra_sum[7:0];
		for (int ch = 0; ch < aob_pkg::NUM_CH; ch++) begin
			bprod[ch] = {16'h0000, bc_s1[ch]} * {8'h00, ba_inv_s1};
		end
	end

	always_comb begin
		for (int ch = 0; ch < aob_pkg::NUM_CH; ch++) begin
			num[ch] = {1'b0, tcta_s2[ch]} + {1'b0, aob_pkg::div255(bprod_s2[ch])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		byp_s1    <= byp;
		pix_s1    <= pix;
		ta_s1     <= top_alpha;
		bc_s1     <= bc;
		ba_inv_s1 <= bottom_alpha * inv;
		for (int ch = 0; ch < aob_pkg::NUM_CH; ch++) begin
			tcta_s1[ch] <= tc[ch] * top_alpha;
		end

		byp_s2 <= byp_s1;
		pix_s2 <= pix_s1;
		ra_s2  <= ra;
		for (int ch = 0; ch < aob_pkg::NUM_CH; ch++) begin
			tcta_s2[ch]  <= tcta_s1[ch];
			bprod_s2[ch] <= bprod[ch];
		end

		byp_s3 <= byp_s2;
		pix_s3 <= pix_s2;
		ra_s3  <= ra_s2;
		for (int ch = 0; ch < aob_pkg::NUM_CH; ch++) begin
			num_s3[ch] <= num[ch];
		end
	end

	// A pass-through pixel divides by one. A channel whose quotient would pass
	// 255 starts with remainder dvsr-1 and all ones below, which yields 255.
	always_comb begin
		tok.valid = valid_s3;
		tok.alpha = byp_s3 ? pix_s3.alpha : ra_s3;
		tok.dvsr  = byp_s3 ? 8'd1 : ra_s3;
		for (int ch = 0; ch < aob_pkg::NUM_CH; ch++) begin
			sat[ch] = num_s3[ch][16:8] >= {1'b0, ra_s3};
			if (byp_s3) begin
				tok.rem[ch] = aob_pkg::CH_ZERO;
				tok.low[ch] = pix_s3.col[ch];
			end else if (sat[ch]) begin
				tok.rem[ch] = ra_s3 - 8'd1;
				tok.low[ch] = aob_pkg::CH_MAX;
			end else begin
				tok.rem[ch] = num_s3[ch][15:8];
				tok.low[ch] = num_s3[ch][7:0];
			end
		end
	end

endmodule
